// ===== rtl/qrv_pkg.sv =====
// qrv_pkg: widths, types and constants shared by the quaternion rotator
// used by rtl/qrv_in_if.sv, rtl/qrv_out_if.sv and rtl/quaternion_rotate_vector.sv
// no dependencies
package qrv_pkg;

	// field widths
	localparam int QUAT_WIDTH     = 16;
	localparam int QUAT_FRAC_BITS = 14;
	localparam int VEC_WIDTH      = 16;
	localparam int OUT_WIDTH      = 18;

	// saturation limits of the result components
	localparam int OUT_MAX = (1 << (OUT_WIDTH - 1)) - 1;
	localparam int OUT_MIN = -(1 << (OUT_WIDTH - 1));

	// internal widths, all exact
	localparam int PROD_W  = 2 * QUAT_WIDTH;            // quaternion component product
	localparam int COEF_W  = PROD_W + 2;                // 2 * (sum of two products)
	localparam int TERM_W  = COEF_W + VEC_WIDTH;        // coefficient * vector component
	localparam int SUM_W   = TERM_W + 2;                // sum of three terms plus rounding
	localparam int SHIFT_W = SUM_W - 2 * QUAT_FRAC_BITS; // sum after dropping the fraction
	localparam int ROW_W   = ((SHIFT_W > VEC_WIDTH) ? SHIFT_W : VEC_WIDTH) + 1;

	typedef logic signed [QUAT_WIDTH-1:0] quat_t;
	typedef logic signed [VEC_WIDTH-1:0]  vec_t;
	typedef logic signed [OUT_WIDTH-1:0]  rot_t;
	typedef logic signed [PROD_W-1:0]     prod_t;
	typedef logic signed [COEF_W-1:0]     coef_t;
	typedef logic signed [TERM_W-1:0]     term_t;
	typedef logic signed [SUM_W-1:0]      sum_t;
	typedef logic signed [SHIFT_W-1:0]    shift_t;
	typedef logic signed [ROW_W-1:0]      row_t;

	// half an output lsb at the fraction position of the matrix products
	localparam sum_t ROUND_HALF = sum_t'(1) <<< (2 * QUAT_FRAC_BITS - 1);

endpackage

// ===== rtl/qrv_in_if.sv =====
// qrv_in_if: input channel of the quaternion rotator, valid/ready plus one item
// depends on qrv_pkg
interface qrv_in_if
	import qrv_pkg::*;
();
	logic  valid;
	logic  ready;
	quat_t quat_w;
	quat_t quat_x;
	quat_t quat_y;
	quat_t quat_z;
	vec_t  vec_x;
	vec_t  vec_y;
	vec_t  vec_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready);
endinterface

// ===== rtl/qrv_out_if.sv =====
// qrv_out_if: result channel of the quaternion rotator, valid/ready plus one item
// depends on qrv_pkg
interface qrv_out_if
	import qrv_pkg::*;
();
	logic valid;
	logic ready;
	rot_t rot_x;
	rot_t rot_y;
	rot_t rot_z;
	logic clipped;

	modport source (output valid, rot_x, rot_y, rot_z, clipped, input ready);
	modport sink (input valid, rot_x, rot_y, rot_z, clipped, output ready);
endinterface

// ===== rtl/quaternion_rotate_vector.sv =====
// quaternion_rotate_vector: rotates a 3-vector by a fixed-point quaternion
// depends on qrv_pkg, qrv_in_if and qrv_out_if
//
// channel   dir  handshake      item
// operand   in   valid/ready    quat_w..quat_z (Q2.14), vec_x..vec_z (signed int)
// result    out  valid/ready    rot_x, rot_y, rot_z (signed 18 bit), clipped
//
// five register stages, one item per cycle sustained while result.ready holds;
// an accepted item moves through stages one to five to the output register
// the throughput is set by the nine 34x16 multipliers of stage three, one per
// matrix entry, so no unit is shared between items
// reset clears only the stage valid bits; data registers are not reset
// a stalled result holds every occupied stage; empty stages still fill, so
// gaps in the stream are squeezed out and the input is taken whenever stage
// one is free or moving on
module quaternion_rotate_vector
	import qrv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	qrv_in_if.sink    operand,
	qrv_out_if.source result
);

	typedef struct packed {
		rot_t value;
		logic clip;
	} sat_t;

	// round has been done already, so only clamp to the output range
	function automatic sat_t saturate(input row_t r);
		sat_t s;
		if (r > row_t'(OUT_MAX)) begin
			s.value = rot_t'(OUT_MAX);
			s.clip  = 1'b1;
		end else if (r < row_t'(OUT_MIN)) begin
			s.value = rot_t'(OUT_MIN);
			s.clip  = 1'b1;
		end else begin
			s.value = rot_t'(r);
			s.clip  = 1'b0;
		end
		return s;
	endfunction

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	// stage enables: a stage loads when it is empty or its content moves on
	logic en1, en2, en3, en4, en5;

	// stage 1: the nine pairwise products of the quaternion
	prod_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	vec_t  v_s1 [3];
	// stage 2: off-identity matrix, row-major
	coef_t c_s2 [9];
	vec_t  v_s2 [3];
	// stage 3: matrix entry times vector component
	term_t t_s3 [9];
	vec_t  v_s3 [3];
	// stage 4: rounded row sums with the identity part added
	row_t  row_s4 [3];
	// stage 5: output register
	rot_t  rot_s5 [3];
	logic  clip_s5;

	assign en5 = !vld_s5 || result.ready;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign operand.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= operand.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: quaternion products, exact in PROD_W bits
	always_ff @(posedge clk) begin
		if (en1) begin
			xx_s1   <= prod_t'(operand.quat_x) * prod_t'(operand.quat_x);
			yy_s1   <= prod_t'(operand.quat_y) * prod_t'(operand.quat_y);
			zz_s1   <= prod_t'(operand.quat_z) * prod_t'(operand.quat_z);
			xy_s1   <= prod_t'(operand.quat_x) * prod_t'(operand.quat_y);
			xz_s1   <= prod_t'(operand.quat_x) * prod_t'(operand.quat_z);
			yz_s1   <= prod_t'(operand.quat_y) * prod_t'(operand.quat_z);
			wx_s1   <= prod_t'(operand.quat_w) * prod_t'(operand.quat_x);
			wy_s1   <= prod_t'(operand.quat_w) * prod_t'(operand.quat_y);
			wz_s1   <= prod_t'(operand.quat_w) * prod_t'(operand.quat_z);
			v_s1[0] <= operand.vec_x;
			v_s1[1] <= operand.vec_y;
			v_s1[2] <= operand.vec_z;
		end
	end

	// stage 2: matrix minus identity, 2F fraction bits
	always_ff @(posedge clk) begin
		if (en2) begin
			c_s2[0] <= -((coef_t'(yy_s1) + coef_t'(zz_s1)) <<< 1);
			c_s2[1] <=  ((coef_t'(xy_s1) - coef_t'(wz_s1)) <<< 1);
			c_s2[2] <=  ((coef_t'(xz_s1) + coef_t'(wy_s1)) <<< 1);
			c_s2[3] <=  ((coef_t'(xy_s1) + coef_t'(wz_s1)) <<< 1);
			c_s2[4] <= -((coef_t'(xx_s1) + coef_t'(zz_s1)) <<< 1);
			c_s2[5] <=  ((coef_t'(yz_s1) - coef_t'(wx_s1)) <<< 1);
			c_s2[6] <=  ((coef_t'(xz_s1) - coef_t'(wy_s1)) <<< 1);
			c_s2[7] <=  ((coef_t'(yz_s1) + coef_t'(wx_s1)) <<< 1);
			c_s2[8] <= -((coef_t'(xx_s1) + coef_t'(yy_s1)) <<< 1);
			v_s2    <= v_s1;
		end
	end

	// stage 3: nine independent multipliers, entry (r,c) times vector component c
	always_ff @(posedge clk) begin
		if (en3) begin
			for (int k = 0; k < 9; k++) begin
				t_s3[k] <= term_t'(c_s2[k]) * term_t'(v_s2[k % 3]);
			end
			v_s3 <= v_s2;
		end
	end

	// stage 4: row sum, round half up at the fraction point, add the identity part
	sum_t   rsum   [3];
	sum_t   rshift [3];
	row_t   rfull  [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rsum[r]   = sum_t'(t_s3[3*r]) + sum_t'(t_s3[3*r+1]) + sum_t'(t_s3[3*r+2])
				+ ROUND_HALF;
			rshift[r] = rsum[r] >>> (2 * QUAT_FRAC_BITS);
			rfull[r]  = row_t'(shift_t'(rshift[r])) + row_t'(v_s3[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			row_s4 <= rfull;
		end
	end

	// stage 5: clamp to 18 bits, flag any clamp
	sat_t sat [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sat[r] = saturate(row_s4[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int r = 0; r < 3; r++) begin
				rot_s5[r] <= sat[r].value;
			end
			clip_s5 <= sat[0].clip | sat[1].clip | sat[2].clip;
		end
	end

	assign result.valid   = vld_s5;
	assign result.rot_x   = rot_s5[0];
	assign result.rot_y   = rot_s5[1];
	assign result.rot_z   = rot_s5[2];
	assign result.clipped = clip_s5;

endmodule
